// ===== src/bps_pkg.sv =====
// Shared constants and types for the byte pattern scanner.
`default_nettype none
package bps_pkg;

  localparam int KeyMax      = 16;
  localparam int AddrBits    = 48;
  localparam int LenBits     = 5;
  localparam int OutAddrBits = 48;
  localparam int CountBits   = 32;
  localparam int CfgBits     = 64;
  localparam int KeyIdxBits  = (KeyMax > 1) ? $clog2(KeyMax) : 1;

  typedef logic [7:0] byte_t;

  typedef enum logic [1:0] {
    CfgKeyLength  = 2'd0,
    CfgKeyLow     = 2'd1,
    CfgKeyHigh    = 2'd2,
    CfgRegionBase = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic  shift;
    logic  in_use;
    byte_t key_byte;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== src/bps_cell.sv =====
// One window cell: holds one byte, passes it on and compares its incoming byte to the key.
`default_nettype none
module bps_cell (
  input  wire logic              clk,
  input  wire bps_pkg::cell_ctl_t ctl,
  input  wire bps_pkg::byte_t    byte_in,
  output bps_pkg::byte_t         byte_out,
  output logic                   equal
);
  import bps_pkg::*;

  byte_t held;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      held <= byte_in;
    end
  end

  assign byte_out = held;
  assign equal    = !ctl.in_use || (byte_in == ctl.key_byte);

endmodule
`default_nettype wire

// ===== src/byte_pattern_scanner.sv =====
// Top level of the byte pattern scanner: window cells, match logic and output register.
//
// The input channel (in_valid, in_ready, data_byte, last_byte) takes one byte of the
// region per beat, in address order; last_byte marks the final byte. The output channel
// (out_valid, out_ready) carries one beat for every byte that completes a key match or
// closes the region, with the match address, the running match count and region_done.
// Configuration is written through cfg_write, cfg_index and cfg_data while the block is
// idle; the user must keep to this, as the block itself does not enforce it.
// Throughput is one byte per cycle while the output is not stalled: each accepted byte
// shifts the row of window cells, and all cells compare in parallel in that same cycle.
// A result appears in the output register in the cycle after its byte is accepted.
// While the receiver stalls, the result waits in the output register and in_ready is
// low; a new byte is taken in the cycle that the waiting result is taken.
// Reset clears the fill count, offset, match count and output valid; the key length
// returns to one and the key bytes and region base to zero. No clearing pass is needed.
`default_nettype none
module byte_pattern_scanner (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [7:0]                         data_byte,
  input  wire logic                               last_byte,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    match_found,
  output logic [bps_pkg::OutAddrBits-1:0]         match_address,
  output logic [bps_pkg::CountBits-1:0]           match_count,
  output logic                                    region_done,
  input  wire logic                               cfg_write,
  input  wire bps_pkg::cfg_index_t                cfg_index,
  input  wire logic [bps_pkg::CfgBits-1:0]        cfg_data
);
  import bps_pkg::*;

  logic [LenBits-1:0]     key_length;
  logic [63:0]            key_low_bytes;
  logic [63:0]            key_high_bytes;
  logic [OutAddrBits-1:0] region_base;

  logic [LenBits-1:0]     fill_count;
  logic [AddrBits-1:0]    byte_offset;
  logic [CountBits-1:0]   matches_seen;

  logic [LenBits-1:0]     used_len;
  logic [LenBits-1:0]     fill_next;
  logic [CountBits-1:0]   count_next;
  logic [AddrBits-1:0]    start_offset;
  logic [AddrBits-1:0]    addr_sum;
  logic [63:0]            addr_ext;
  logic                   accept;
  logic                   hit;
  logic                   produce;

  byte_t                  key_bytes [KeyMax];
  byte_t                  chain     [KeyMax+1];
  cell_ctl_t              cell_ctl  [KeyMax];
  logic [KeyMax-1:0]      cell_equal;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length     <= LenBits'(1);
      key_low_bytes  <= '0;
      key_high_bytes <= '0;
      region_base    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CfgKeyLength:  key_length     <= cfg_data[LenBits-1:0];
        CfgKeyLow:     key_low_bytes  <= cfg_data[63:0];
        CfgKeyHigh:    key_high_bytes <= cfg_data[63:0];
        CfgRegionBase: region_base    <= cfg_data[OutAddrBits-1:0];
      endcase
    end
  end

  always_comb begin
    if (key_length == '0) begin
      used_len = LenBits'(1);
    end else if (key_length > LenBits'(KeyMax)) begin
      used_len = LenBits'(KeyMax);
    end else begin
      used_len = key_length;
    end
  end

  always_comb begin
    for (int i = 0; i < KeyMax; i++) begin
      if (i < 8) begin
        key_bytes[i] = key_low_bytes[8*i +: 8];
      end else begin
        key_bytes[i] = key_high_bytes[8*(i-8) +: 8];
      end
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign chain[0] = data_byte;

  // Cell j holds window position j after the shift and meets key byte len-1-j.
  always_comb begin
    logic [LenBits-1:0] idx;
    for (int j = 0; j < KeyMax; j++) begin
      idx                  = used_len - LenBits'(1) - LenBits'(j);
      cell_ctl[j].shift    = accept;
      cell_ctl[j].in_use   = LenBits'(j) < used_len;
      cell_ctl[j].key_byte = key_bytes[idx[KeyIdxBits-1:0]];
    end
  end

  for (genvar j = 0; j < KeyMax; j++) begin : g_cell
    bps_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl[j]),
      .byte_in  (chain[j]),
      .byte_out (chain[j+1]),
      .equal    (cell_equal[j])
    );
  end

  assign fill_next    = (fill_count < LenBits'(KeyMax)) ? fill_count + LenBits'(1) : fill_count;
  assign hit          = (fill_next >= used_len) && (&cell_equal);
  assign produce      = hit || last_byte;
  assign count_next   = (hit && (matches_seen != '1)) ? matches_seen + CountBits'(1)
                                                      : matches_seen;
  assign start_offset = byte_offset - AddrBits'(used_len - LenBits'(1));
  assign addr_sum     = AddrBits'(region_base) + start_offset;
  assign addr_ext     = 64'(addr_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count   <= '0;
      byte_offset  <= '0;
      matches_seen <= '0;
    end else if (accept) begin
      if (last_byte) begin
        fill_count   <= '0;
        byte_offset  <= '0;
        matches_seen <= '0;
      end else begin
        fill_count   <= hit ? '0 : fill_next;
        byte_offset  <= byte_offset + AddrBits'(1);
        matches_seen <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= accept && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && produce) begin
      match_found   <= hit;
      match_address <= hit ? addr_ext[OutAddrBits-1:0] : '0;
      match_count   <= count_next;
      region_done   <= last_byte;
    end
  end

  a_result_has_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (match_found || region_done))
    else $error("result beat with neither a match nor end of region");

  a_match_counted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && match_found) |-> (match_count != '0))
    else $error("match reported with zero count");

  a_region_cleared: assert property (@(posedge clk) disable iff (rst)
    (accept && last_byte) |=> (fill_count == '0 && byte_offset == '0 && matches_seen == '0))
    else $error("region state not cleared after last byte");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill_count <= LenBits'(KeyMax))
    else $error("fill count beyond window depth");

endmodule
`default_nettype wire
